// File: rtl/ale_pkg.sv
// Shared types and constants for the array list engine.
package ale_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned IndexW = 6;
  localparam int unsigned StatW  = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_HEAD   = 2'd0,
    REQ_TAIL   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_APPEND,
    CELL_MATCH,
    CELL_PULL
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_PULL
  } state_e;

  typedef struct packed {
    cell_op_e         op;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

// File: rtl/array_list_engine.sv
// Array list engine: ordered list held in a chain of shifting cells.
// Head insert, append and read finish when accepted; remove compares in every
// cell on accept, then in ST_PULL the first-match flag ripples down the chain
// and the tail shifts left. Result sits in an output register; one request is
// in flight at a time. Reset (rst_ni, async, low) empties the list.
module array_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ale_pkg::ReqW-1:0]          req_type_i,
  input  logic signed [ale_pkg::DataW-1:0]  value_i,
  input  logic [ale_pkg::IndexW-1:0]        index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ale_pkg::StatW-1:0]         status_o,
  output logic signed [ale_pkg::DataW-1:0]  read_value_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o,
  output logic                              is_empty_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > ale_pkg::IndexW) ? CntW : ale_pkg::IndexW;

  ale_pkg::state_e              state_q, state_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic                         out_valid_q;
  ale_pkg::status_e             status_q, status_d;
  logic [ale_pkg::DataW-1:0]    rd_q, rd_d;
  logic [CntW-1:0]              count_q;
  logic                         empty_q;
  logic                         load;
  logic                         accept;
  logic                         full;
  ale_pkg::req_e                req;
  ale_pkg::cell_ctrl_t          ctrl;
  logic [ale_pkg::DataW-1:0]    cell_data [DEPTH];
  logic [DEPTH:0]               seen;
  logic [ale_pkg::DataW-1:0]    mux_data;
  logic                         idx_ok;

  assign in_ready_o = (state_q == ale_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = fill_q == CntW'(DEPTH);
  assign req        = ale_pkg::req_e'(req_type_i);
  assign idx_ok     = CmpW'(index_i) < CmpW'(fill_q);
  assign seen[0]    = 1'b0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ale_pkg::DataW-1:0] left_data;
    logic [ale_pkg::DataW-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = ctrl.value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    ale_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .fill_i       (fill_q),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .seen_i       (seen[i]),
      .data_o       (cell_data[i]),
      .seen_o       (seen[i+1])
    );
  end

  // Read select
  always_comb begin
    mux_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CmpW'(index_i) == CmpW'(i)) begin
        mux_data = cell_data[i];
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ale_pkg::ST_IDLE: begin
        if (accept && (req == ale_pkg::REQ_REMOVE) && (fill_q != '0)) begin
          state_d = ale_pkg::ST_PULL;
        end
      end
      ale_pkg::ST_PULL: begin
        state_d = ale_pkg::ST_IDLE;
      end
      default: begin
        state_d = ale_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.op    = ale_pkg::CELL_HOLD;
    ctrl.value = value_i;
    load       = 1'b0;
    status_d   = ale_pkg::STAT_OK;
    rd_d       = '0;
    fill_d     = fill_q;
    case (state_q)
      ale_pkg::ST_IDLE: begin
        if (accept) begin
          case (req)
            ale_pkg::REQ_HEAD: begin
              load = 1'b1;
              if (full) begin
                status_d = ale_pkg::STAT_FULL;
              end else begin
                ctrl.op = ale_pkg::CELL_PUSH;
                fill_d  = fill_q + 1'b1;
              end
            end
            ale_pkg::REQ_TAIL: begin
              load = 1'b1;
              if (full) begin
                status_d = ale_pkg::STAT_FULL;
              end else begin
                ctrl.op = ale_pkg::CELL_APPEND;
                fill_d  = fill_q + 1'b1;
              end
            end
            ale_pkg::REQ_REMOVE: begin
              if (fill_q == '0) begin
                load     = 1'b1;
                status_d = ale_pkg::STAT_EMPTY;
              end else begin
                ctrl.op = ale_pkg::CELL_MATCH;
              end
            end
            ale_pkg::REQ_READ: begin
              load = 1'b1;
              if (idx_ok) begin
                rd_d = mux_data;
              end else begin
                status_d = ale_pkg::STAT_BAD_INDEX;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      ale_pkg::ST_PULL: begin
        ctrl.op = ale_pkg::CELL_PULL;
        load    = 1'b1;
        if (seen[DEPTH]) begin
          fill_d = fill_q - 1'b1;
        end else begin
          status_d = ale_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ale_pkg::ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      count_q  <= fill_d;
      empty_q  <= fill_d == '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rd_q;
  assign count_o      = count_q;
  assign is_empty_o   = empty_q;

endmodule

// File: rtl/ale_cell.sv
// One list slot: holds an entry, shifts with its neighbors, flags a match.
module ale_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic                      clk_i,
  input  ale_pkg::cell_ctrl_t       ctrl_i,
  input  logic [CntW-1:0]           fill_i,
  input  logic [ale_pkg::DataW-1:0] left_data_i,
  input  logic [ale_pkg::DataW-1:0] right_data_i,
  input  logic                      seen_i,
  output logic [ale_pkg::DataW-1:0] data_o,
  output logic                      seen_o
);

  logic [ale_pkg::DataW-1:0] data_q, data_d;
  logic                      hit_q, hit_d;
  logic                      held;

  assign held   = CntW'(Idx) < fill_i;
  assign seen_o = seen_i | hit_q;
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    case (ctrl_i.op)
      ale_pkg::CELL_PUSH: begin
        data_d = (Idx == 0) ? ctrl_i.value : left_data_i;
      end
      ale_pkg::CELL_APPEND: begin
        if (CntW'(Idx) == fill_i) begin
          data_d = ctrl_i.value;
        end
      end
      ale_pkg::CELL_MATCH: begin
        hit_d = held && (data_q == ctrl_i.value);
      end
      ale_pkg::CELL_PULL: begin
        if (seen_o) begin
          data_d = right_data_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hit_q  <= hit_d;
  end

endmodule

// File: verif/array_list_engine_test.sv
// Self-checking testbench for the array list engine: directed table, then random phases.
`timescale 1ns / 100ps

module array_list_engine_test;

  localparam int Depth       = 64;
  localparam int CountW      = $clog2(Depth + 1);
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 205;
  localparam int HoldCycles  = 80;
  localparam int PressurePhase = 0;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    ale_pkg::status_e          status;
    logic [ale_pkg::DataW-1:0] rd;
    logic [CountW-1:0]         count;
    logic                      empty;
  } list_result_t;

  typedef struct packed {
    ale_pkg::req_e              req;
    logic [ale_pkg::DataW-1:0]  value;
    logic [ale_pkg::IndexW-1:0] index;
    bit                         typed;
    list_result_t               want;
  } dir_row_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  localparam dir_row_t DirRows [17] = '{
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd0,  1'b1,
      '{ale_pkg::STAT_BAD_INDEX, 32'h0, 7'd0, 1'b1}},
    '{ale_pkg::REQ_REMOVE, 32'h0000_0000, 6'd0,  1'b1,
      '{ale_pkg::STAT_EMPTY, 32'h0, 7'd0, 1'b1}},
    '{ale_pkg::REQ_TAIL,   32'h7FFF_FFFF, 6'd0,  1'b1,
      '{ale_pkg::STAT_OK, 32'h0, 7'd1, 1'b0}},
    '{ale_pkg::REQ_HEAD,   32'h8000_0000, 6'd0,  1'b1,
      '{ale_pkg::STAT_OK, 32'h0, 7'd2, 1'b0}},
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd0,  1'b1,
      '{ale_pkg::STAT_OK, 32'h8000_0000, 7'd2, 1'b0}},
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd1,  1'b1,
      '{ale_pkg::STAT_OK, 32'h7FFF_FFFF, 7'd2, 1'b0}},
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd2,  1'b1,
      '{ale_pkg::STAT_BAD_INDEX, 32'h0, 7'd2, 1'b0}},
    '{ale_pkg::REQ_READ,   32'hFFFF_FFFF, 6'd63, 1'b1,
      '{ale_pkg::STAT_BAD_INDEX, 32'h0, 7'd2, 1'b0}},
    '{ale_pkg::REQ_REMOVE, 32'h7FFF_FFFE, 6'd0,  1'b1,
      '{ale_pkg::STAT_NOT_FOUND, 32'h0, 7'd2, 1'b0}},
    '{ale_pkg::REQ_HEAD,   32'hFFFF_FFFF, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_TAIL,   32'h0000_0000, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_REMOVE, 32'h7FFF_FFFF, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd1,  1'b0, '0},
    '{ale_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_REMOVE, 32'h0000_0000, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_READ,   32'h0000_0000, 6'd0,  1'b0, '0},
    '{ale_pkg::REQ_REMOVE, 32'h8000_0000, 6'd0,  1'b1,
      '{ale_pkg::STAT_OK, 32'h0, 7'd0, 1'b1}}
  };

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic [ale_pkg::ReqW-1:0]          req_type_i  = '0;
  logic signed [ale_pkg::DataW-1:0]  value_i     = '0;
  logic [ale_pkg::IndexW-1:0]        index_i     = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [ale_pkg::StatW-1:0]         status_o;
  logic signed [ale_pkg::DataW-1:0]  read_value_o;
  logic [CountW-1:0]                 count_o;
  logic                              is_empty_o;

  logic [ale_pkg::DataW-1:0] list_mem [Depth];
  int                        list_len = 0;
  list_result_t              list_results_due [$];

  int          err_count     = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          phase_id      = -1;
  int          hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned cycle_count   = 0;

  array_list_engine #(.DEPTH(Depth)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic list_result_t list_apply(ale_pkg::req_e req,
                                              logic [ale_pkg::DataW-1:0] val,
                                              logic [ale_pkg::IndexW-1:0] idx);
    list_result_t res;
    int pos;
    res = '{ale_pkg::STAT_OK, 32'h0, 7'd0, 1'b0};
    case (req)
      ale_pkg::REQ_HEAD, ale_pkg::REQ_TAIL: begin
        if (list_len >= Depth) begin
          res.status = ale_pkg::STAT_FULL;
        end else begin
          if (req == ale_pkg::REQ_HEAD) begin
            for (int i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
            list_mem[0] = val;
          end else begin
            list_mem[list_len] = val;
          end
          list_len++;
        end
      end
      ale_pkg::REQ_REMOVE: begin
        if (list_len == 0) begin
          res.status = ale_pkg::STAT_EMPTY;
        end else begin
          pos = 0;
          while (pos < list_len && list_mem[pos] !== val) pos++;
          if (pos == list_len) begin
            res.status = ale_pkg::STAT_NOT_FOUND;
          end else begin
            for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
            list_len--;
          end
        end
      end
      default: begin
        if (int'(idx) >= list_len) res.status = ale_pkg::STAT_BAD_INDEX;
        else res.rd = list_mem[idx];
      end
    endcase
    res.count = CountW'(list_len);
    res.empty = (list_len == 0);
    return res;
  endfunction

  // small pool with repeats and sign extremes, else full-range random
  function automatic logic [ale_pkg::DataW-1:0] pick_value();
    case ($urandom_range(5))
      0, 1: return {$urandom_range(1) ? 29'h1FFF_FFFF : 29'h0, 3'($urandom_range(7))};
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic offer_word(ale_pkg::req_e req, logic [ale_pkg::DataW-1:0] val,
                            logic [ale_pkg::IndexW-1:0] idx,
                            bit typed, list_result_t want);
    list_result_t pred;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    index_i    <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pred = list_apply(req, val, idx);
    list_results_due.push_back(typed ? want : pred);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic offer_random(mix_e mix);
    int r;
    ale_pkg::req_e req;
    logic [ale_pkg::DataW-1:0] val;
    logic [ale_pkg::IndexW-1:0] idx;
    r = $urandom_range(99);
    case (mix)
      MIX_GROW:   req = r < 40 ? ale_pkg::REQ_HEAD : r < 75 ? ale_pkg::REQ_TAIL :
                        r < 88 ? ale_pkg::REQ_REMOVE : ale_pkg::REQ_READ;
      MIX_SHRINK: req = r < 12 ? ale_pkg::REQ_HEAD : r < 24 ? ale_pkg::REQ_TAIL :
                        r < 75 ? ale_pkg::REQ_REMOVE : ale_pkg::REQ_READ;
      default:    req = r < 25 ? ale_pkg::REQ_HEAD : r < 50 ? ale_pkg::REQ_TAIL :
                        r < 75 ? ale_pkg::REQ_REMOVE : ale_pkg::REQ_READ;
    endcase
    val = pick_value();
    if (req == ale_pkg::REQ_REMOVE && list_len > 0 && $urandom_range(9) < 6)
      val = list_mem[$urandom_range(list_len - 1)];
    if ($urandom_range(1)) idx = ale_pkg::IndexW'($urandom_range(63));
    else idx = ale_pkg::IndexW'(list_len >= Depth ? Depth - 1 : $urandom_range(list_len));
    offer_word(req, val, idx, 1'b0, '0);
  endtask

  task automatic drain_list_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (list_results_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (phase_id == PressurePhase && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (list_results_due.size() == 0) begin
        $error("result word with nothing expected");
        err_count++;
      end else begin
        want = list_results_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          err_count++;
        end
        if (read_value_o !== want.rd) begin
          $error("read_value: expected %0d, got %0d", $signed(want.rd), read_value_o);
          err_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          err_count++;
        end
        if (is_empty_o !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, is_empty_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DirRows[k])
      offer_word(DirRows[k].req, DirRows[k].value, DirRows[k].index,
                 DirRows[k].typed, DirRows[k].want);
    drain_list_results();
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 73; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 73; end
        default: begin send_idle_pct = 19; stall_pct <= 19; end
      endcase
      phase_id <= ph;
      repeat (PhaseItems) offer_random(mix_e'(ph % 3));
      drain_list_results();
    end
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
